>>> rtl/core/b32cd_pkg.sv
`timescale 1ns / 1ps

package b32cd_pkg;

  // field widths
  localparam int unsigned SymW   = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned AccW   = 12;
  localparam int unsigned FillW  = 4;
  localparam int unsigned ValW   = 5;

  // tdata of the result beat: data_byte then byte_count
  localparam int unsigned OutDataW = ByteW + CountW;

  // reset value of the byte limit
  localparam logic [CountW-1:0] MaxBytesReset = 16'hFFFF;

  // bits per decoded byte, as a fill level
  localparam logic [FillW-1:0] FillByte = 4'd8;
  localparam logic [FillW-1:0] FillSym  = 4'd5;

  // character codes bounding the alphabet ranges
  localparam logic [SymW-1:0] ChLowA  = 8'h61;
  localparam logic [SymW-1:0] ChLowZ  = 8'h7A;
  localparam logic [SymW-1:0] ChUpA   = 8'h41;
  localparam logic [SymW-1:0] ChUpZ   = 8'h5A;
  localparam logic [SymW-1:0] ChDig0  = 8'h30;
  localparam logic [SymW-1:0] ChDig5  = 8'h35;
  localparam logic [SymW-1:0] ChNul   = 8'h00;
  localparam logic [ValW-1:0] DigBase = 5'd26;

  // one result item
  typedef struct packed {
    logic              byte_valid;
    logic [ByteW-1:0]  data_byte;
    logic              message_done;
    logic [CountW-1:0] byte_count;
  } result_t;

  // 5-bit value of an encoded character, zero for anything outside the alphabet
  function automatic logic [ValW-1:0] symbol_value(input logic [SymW-1:0] c);
    logic [SymW-1:0] diff;
    begin
      diff = '0;
      if (c >= ChLowA && c <= ChLowZ) begin
        diff = c - ChLowA;
        return diff[ValW-1:0];
      end else if (c >= ChUpA && c <= ChUpZ) begin
        diff = c - ChUpA;
        return diff[ValW-1:0];
      end else if (c >= ChDig0 && c <= ChDig5) begin
        diff = c - ChDig0;
        return DigBase + diff[ValW-1:0];
      end
      return '0;
    end
  endfunction

endpackage

>>> rtl/core/b32cd_core.sv
`timescale 1ns / 1ps

module b32cd_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [b32cd_pkg::SymW-1:0]     symbol_i,
  input  logic                           last_i,
  input  logic [b32cd_pkg::CountW-1:0]   max_bytes_i,
  output b32cd_pkg::result_t             result_o
);

  logic [b32cd_pkg::AccW-1:0]   acc_q, acc_d;
  logic [b32cd_pkg::FillW-1:0]  fill_q, fill_d;
  logic [b32cd_pkg::CountW-1:0] done_q, done_d;
  logic                         halted_q, halted_d;

  logic                         halt_now;
  logic                         decoding;
  logic [b32cd_pkg::ValW-1:0]   sym_val;
  logic [b32cd_pkg::AccW-1:0]   acc_sh;
  logic [b32cd_pkg::FillW-1:0]  fill_sum;
  logic [b32cd_pkg::FillW-1:0]  fill_rem;
  logic [b32cd_pkg::AccW-1:0]   acc_shr;
  logic [b32cd_pkg::AccW-1:0]   keep_mask;
  logic                         emit;

  // stop on nul or when the byte limit is already reached
  assign halt_now = !halted_q && (symbol_i == b32cd_pkg::ChNul || done_q >= max_bytes_i);
  assign decoding = !halted_q && !halt_now;
  assign sym_val  = b32cd_pkg::symbol_value(symbol_i);

  // append five bits; at most seven bits are pending before the append
  assign acc_sh   = {acc_q[b32cd_pkg::AccW-b32cd_pkg::ValW-1:0], sym_val};
  assign fill_sum = fill_q + b32cd_pkg::FillSym;
  assign emit     = decoding && (fill_sum >= b32cd_pkg::FillByte);
  assign fill_rem = fill_sum - b32cd_pkg::FillByte;
  assign acc_shr  = acc_sh >> fill_rem;
  assign keep_mask = ({{(b32cd_pkg::AccW-1){1'b0}}, 1'b1} << fill_rem)
                     - {{(b32cd_pkg::AccW-1){1'b0}}, 1'b1};

  // result and next state
  always_comb begin
    acc_d    = acc_q;
    fill_d   = fill_q;
    done_d   = done_q;
    halted_d = halted_q;
    result_o.byte_valid   = 1'b0;
    result_o.data_byte    = '0;
    result_o.message_done = last_i;
    if (halt_now) begin
      halted_d = 1'b1;
    end else if (decoding) begin
      if (emit) begin
        result_o.byte_valid = 1'b1;
        result_o.data_byte  = acc_shr[b32cd_pkg::ByteW-1:0];
        acc_d  = acc_sh & keep_mask;
        fill_d = fill_rem;
        done_d = done_q + {{(b32cd_pkg::CountW-1){1'b0}}, 1'b1};
      end else begin
        acc_d  = acc_sh;
        fill_d = fill_sum;
      end
    end
    result_o.byte_count = done_d;
    // end of message clears everything
    if (last_i) begin
      acc_d    = '0;
      fill_d   = '0;
      done_d   = '0;
      halted_d = 1'b0;
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      fill_q   <= '0;
      done_q   <= '0;
      halted_q <= 1'b0;
    end else if (step_i) begin
      acc_q    <= acc_d;
      fill_q   <= fill_d;
      done_q   <= done_d;
      halted_q <= halted_d;
    end
  end

endmodule

>>> rtl/core/base32_char_decoder_unit.sv
`timescale 1ns / 1ps

// Streaming unpadded base32 decoder. One character enters per beat on the slave side
// (tdata = symbol, tlast = end of message) and exactly one result beat leaves on the
// master side for each: tuser = byte_valid, tdata = data_byte then byte_count from the
// lowest bit up, tlast = message_done. An item passes through the input register and
// then the result register; a new character is taken every cycle while the master
// side keeps up, the limit being the combinational state update (character range
// checks, 12-bit shift and the byte-count compare). Letters of either case and digits
// 0-5 are decoded, any other code decodes as zero bits; a nul or reaching max_bytes
// stops decoding until tlast. The byte limit (cfg_valid_i/cfg_data_i) resets to 65535;
// the user must write it only while no message is in flight; the block does not check.
module base32_char_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // byte limit write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [b32cd_pkg::CountW-1:0]       cfg_data_i,    // max_bytes
  // character beats
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [b32cd_pkg::SymW-1:0]         s_axis_tdata,  // symbol
  input  logic                               s_axis_tlast,  // end_of_message
  // result beats
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [b32cd_pkg::OutDataW-1:0]     m_axis_tdata,  // data_byte, byte_count
  output logic                               m_axis_tuser,  // byte_valid
  output logic                               m_axis_tlast   // message_done
);

  logic [b32cd_pkg::CountW-1:0] max_bytes_q;
  logic                         in_valid_q;
  logic [b32cd_pkg::SymW-1:0]   sym_q;
  logic                         last_q;
  logic                         out_valid_q;
  b32cd_pkg::result_t           res_q;
  b32cd_pkg::result_t           res_d;
  logic                         out_free;
  logic                         step;
  logic                         in_beat;

  // byte limit register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= b32cd_pkg::MaxBytesReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_bytes_q <= cfg_data_i;
    end
  end

  // handshake between the two stages
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      sym_q  <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  // decode step with message state
  b32cd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .symbol_i    (sym_q),
    .last_i      (last_q),
    .max_bytes_i (max_bytes_q),
    .result_o    (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.byte_count, res_q.data_byte};
  assign m_axis_tuser  = res_q.byte_valid;
  assign m_axis_tlast  = res_q.message_done;

endmodule

>>> rtl/core/b32cd_checker.sv
`timescale 1ns / 1ps

module b32cd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [b32cd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  // result register empties during reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result beat valid right after reset");

  // input only stalls when a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with the output side free");

  // no decoded byte means a zero data byte
  a_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[b32cd_pkg::ByteW-1:0] == '0)
    else $error("data byte set without byte_valid");

  // a decoded byte is always counted
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[b32cd_pkg::OutDataW-1:b32cd_pkg::ByteW] != '0)
    else $error("decoded byte with zero byte count");

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

endmodule

bind base32_char_decoder_unit b32cd_checker u_b32cd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
